// ===== rtl/core/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg
// Types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam logic [7:0] LIMIT_RESET = 8'd100;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] HEX_BASE_LETTER = 8'd10;

    typedef enum logic [3:0] {
        PH_NUM       = 4'd0,
        PH_REST      = 4'd1,
        PH_EXT       = 4'd2,
        PH_DATA      = 4'd3,
        PH_DATA_CR   = 4'd4,
        PH_DATA_LF   = 4'd5,
        PH_TRL_START = 4'd6,
        PH_TRL_CR    = 4'd7,
        PH_TRL_LINE  = 4'd8,
        PH_CLOSED    = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        NP_BLANKS = 2'd0,
        NP_ZERO   = 2'd1,
        NP_ZERO_X = 2'd2,
        NP_DIGITS = 2'd3
    } num_phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        phase_t     phase;
        num_phase_t num_phase;
        logic [7:0] line_count;
    } ctrl_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.digit = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            h.digit = c[3:0];
        end
        else if (c >= CH_A_LO && c <= CH_F_LO)
        begin
            h.digit = 4'(c - CH_A_LO + HEX_BASE_LETTER);
        end
        else if (c >= CH_A_UP && c <= CH_F_UP)
        begin
            h.digit = 4'(c - CH_A_UP + HEX_BASE_LETTER);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

// ===== rtl/core/chd_step.sv =====
// ----------------------------------------------------------------------------
// chd_step
// Next-state and result logic for one coded byte of the chunked body.
// ----------------------------------------------------------------------------
module chd_step #(
    parameter int SIZE_BITS = 32
) (
    input  logic [7:0]           in_byte,
    input  logic [7:0]           limit,
    input  chd_pkg::ctrl_state_t cur,
    input  logic [SIZE_BITS-1:0] rem,
    output chd_pkg::ctrl_state_t nxt,
    output logic [SIZE_BITS-1:0] rem_next,
    output logic                 emit,
    output chd_pkg::result_t     res
);

    chd_pkg::hex_t hex;
    logic          line_full;
    logic          size_full;
    logic          rem_zero;
    logic          is_lf;
    logic          is_cr;

    assign hex       = chd_pkg::hex_decode(in_byte);
    assign line_full = cur.line_count >= limit;
    assign size_full = rem[SIZE_BITS-1 -: 4] != 4'd0;
    assign rem_zero  = rem == '0;
    assign is_lf     = in_byte == chd_pkg::CH_LF;
    assign is_cr     = in_byte == chd_pkg::CH_CR;

    always_comb
    begin
        nxt      = cur;
        rem_next = rem;
        emit     = 1'b0;
        res.kind = chd_pkg::KIND_PAYLOAD;
        res.data = 8'h00;
        res.last = 1'b0;
        case (cur.phase)
            chd_pkg::PH_NUM, chd_pkg::PH_REST:
            begin
                if (is_lf)
                begin
                    nxt.phase = rem_zero ? chd_pkg::PH_TRL_START : chd_pkg::PH_DATA;
                end
                else if (in_byte == chd_pkg::CH_SEMI)
                begin
                    nxt.phase = chd_pkg::PH_EXT;
                end
                else if (line_full)
                begin
                    nxt.phase = chd_pkg::PH_CLOSED;
                    emit      = 1'b1;
                    res.kind  = chd_pkg::KIND_ERROR;
                end
                else
                begin
                    nxt.line_count = cur.line_count + 8'd1;
                    if (cur.phase == chd_pkg::PH_NUM)
                    begin
                        if (cur.num_phase == chd_pkg::NP_BLANKS &&
                            chd_pkg::is_blank(in_byte))
                        begin
                            nxt.num_phase = chd_pkg::NP_BLANKS;
                        end
                        else if (cur.num_phase == chd_pkg::NP_BLANKS &&
                                 in_byte == chd_pkg::CH_0)
                        begin
                            nxt.num_phase = chd_pkg::NP_ZERO;
                        end
                        else if (cur.num_phase == chd_pkg::NP_ZERO &&
                                 (in_byte == chd_pkg::CH_X_LO ||
                                  in_byte == chd_pkg::CH_X_UP))
                        begin
                            nxt.num_phase = chd_pkg::NP_ZERO_X;
                        end
                        else if (!hex.ok)
                        begin
                            nxt.phase = chd_pkg::PH_REST;
                        end
                        else if (size_full)
                        begin
                            nxt.phase = chd_pkg::PH_CLOSED;
                            emit      = 1'b1;
                            res.kind  = chd_pkg::KIND_ERROR;
                        end
                        else
                        begin
                            rem_next      = {rem[SIZE_BITS-5:0], hex.digit};
                            nxt.num_phase = chd_pkg::NP_DIGITS;
                        end
                    end
                end
            end
            chd_pkg::PH_EXT:
            begin
                if (is_lf)
                begin
                    nxt.phase = rem_zero ? chd_pkg::PH_TRL_START : chd_pkg::PH_DATA;
                end
            end
            chd_pkg::PH_DATA:
            begin
                emit     = 1'b1;
                res.data = in_byte;
                res.last = rem <= SIZE_BITS'(1);
                if (res.last)
                begin
                    rem_next  = '0;
                    nxt.phase = chd_pkg::PH_DATA_CR;
                end
                else
                begin
                    rem_next = rem - SIZE_BITS'(1);
                end
            end
            chd_pkg::PH_DATA_CR, chd_pkg::PH_DATA_LF:
            begin
                if (is_cr && cur.phase == chd_pkg::PH_DATA_CR)
                begin
                    nxt.phase = chd_pkg::PH_DATA_LF;
                end
                else if (is_lf)
                begin
                    nxt.phase      = chd_pkg::PH_NUM;
                    nxt.num_phase  = chd_pkg::NP_BLANKS;
                    nxt.line_count = 8'd0;
                    rem_next       = '0;
                end
                else
                begin
                    nxt.phase = chd_pkg::PH_CLOSED;
                    emit      = 1'b1;
                    res.kind  = chd_pkg::KIND_ERROR;
                end
            end
            chd_pkg::PH_TRL_START, chd_pkg::PH_TRL_CR:
            begin
                if (is_cr && cur.phase == chd_pkg::PH_TRL_START)
                begin
                    nxt.phase = chd_pkg::PH_TRL_CR;
                end
                else if (is_lf)
                begin
                    nxt.phase = chd_pkg::PH_CLOSED;
                    emit      = 1'b1;
                    res.kind  = chd_pkg::KIND_END;
                end
                else
                begin
                    nxt.phase = chd_pkg::PH_TRL_LINE;
                end
            end
            chd_pkg::PH_TRL_LINE:
            begin
                if (is_lf)
                begin
                    nxt.phase = chd_pkg::PH_TRL_START;
                end
            end
            default:
            begin
                nxt.phase = chd_pkg::PH_CLOSED;
            end
        endcase
    end

endmodule

// ===== rtl/core/chd_out_buf.sv =====
// ----------------------------------------------------------------------------
// chd_out_buf
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module chd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  chd_pkg::result_t res,
    output logic             free,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser
);

    logic             valid_reg;
    logic             valid_next;
    chd_pkg::result_t res_reg;

    assign free       = !valid_reg || m_axis_tready;
    assign valid_next = load || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.data;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tuser  = res_reg.kind;

endmodule

// ===== rtl/core/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked-coded body byte by byte into payload bytes and end or error results.
//
//   channel   dir   handshake                    payload
//   s_axis    in    s_axis_tvalid/tready         tdata: in_byte
//   m_axis    out   m_axis_tvalid/tready         tdata: payload_byte,
//                                                tuser: kind, tlast: chunk_last
//   cfg       in    cfg_valid/cfg_ready          cfg_data: size_line_limit
//
// One byte per cycle sustained while m_axis does not stall; a taken byte
// goes to the input register, and its result, if any, to the result register.
// Reset opens a new body with size_line_limit at 100.
// A stalled result register holds the byte in the input register and drops
// s_axis_tready until the result is taken.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           in_byte_reg;
    logic [7:0]           limit_reg;
    chd_pkg::ctrl_state_t state_reg;
    chd_pkg::ctrl_state_t state_next;
    logic [SIZE_BITS-1:0] rem_reg;
    logic [SIZE_BITS-1:0] rem_next;
    logic                 out_free;
    logic                 process;
    logic                 emit;
    chd_pkg::result_t     res;

    assign cfg_ready     = 1'b1;
    assign process       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_valid_next = s_axis_tvalid || (in_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            limit_reg            <= chd_pkg::LIMIT_RESET;
            state_reg.phase      <= chd_pkg::PH_NUM;
            state_reg.num_phase  <= chd_pkg::NP_BLANKS;
            state_reg.line_count <= 8'd0;
            rem_reg              <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= in_valid_next;
            end
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (process)
            begin
                state_reg <= state_next;
                rem_reg   <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    chd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .in_byte  (in_byte_reg),
        .limit    (limit_reg),
        .cur      (state_reg),
        .rem      (rem_reg),
        .nxt      (state_next),
        .rem_next (rem_next),
        .emit     (emit),
        .res      (res)
    );

    chd_out_buf u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (process && emit),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_closed_stays: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == chd_pkg::PH_CLOSED |=> state_reg.phase == chd_pkg::PH_CLOSED)
        else $error("decoder reopened after close");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        process && emit && res.kind != chd_pkg::KIND_PAYLOAD
        |=> state_reg.phase == chd_pkg::PH_CLOSED)
        else $error("end or error result without close");

    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == chd_pkg::KIND_PAYLOAD)
        else $error("tlast on non-payload result");

    a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != chd_pkg::KIND_PAYLOAD |-> m_axis_tdata == 8'h00)
        else $error("non-payload result carries data");

    a_no_result_closed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == chd_pkg::PH_CLOSED |-> !emit)
        else $error("result emitted while closed");
`endif

endmodule
